// ===== sv/ppi_pkg.sv =====
// Shared types and constants for the 8255-style port controller.
package ppi_pkg;

  typedef enum logic [1:0] {
    REQ_READ       = 2'd0,
    REQ_WRITE      = 2'd1,
    REQ_CLEAR_SCAN = 2'd2,
    REQ_NOP        = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PORT_A    = 2'd0,
    PORT_B    = 2'd1,
    PORT_C    = 2'd2,
    PORT_CTRL = 2'd3
  } port_t;

  typedef enum logic [1:0] {
    BUS_INACTIVE = 2'd0,
    BUS_READ     = 2'd1,
    BUS_WRITE    = 2'd2,
    BUS_SELECT   = 2'd3
  } bus_mode_t;

  typedef enum logic {
    CFG_MAKER_ID = 1'b0,
    CFG_REFRESH  = 1'b1
  } cfg_index_t;

  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] KEYBOARD_REG = 8'd14;
  localparam logic [2:0] MAKER_RESET  = 3'd7;
  localparam logic       REFRESH_RESET = 1'b1;

  // Control word bit positions
  localparam int CW_MODE_SET = 7;
  localparam int CW_A_IN     = 4;
  localparam int CW_CH_IN    = 3;
  localparam int CW_CL_IN    = 0;
  localparam int CW_BIT_VAL  = 0;

  typedef struct packed {
    req_t        req_type;
    port_t       port_sel;
    logic [7:0]  write_data;
    logic [7:0]  key_row_data;
    logic [7:0]  sound_read_data;
    logic        vsync;
    logic        tape_in;
    logic [7:0]  port_c_pins;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  port_a_out;
    logic [7:0]  port_c_out;
    logic [3:0]  keyboard_row;
    bus_mode_t   sound_bus_mode;
    logic [7:0]  sound_reg_sel;
    logic        sound_write_strobe;
    logic        keyboard_scanned;
  } out_beat_t;

endpackage

// ===== sv/ppi8255_port_controller.sv =====
// Top level of the mode-0 8255-style parallel port controller.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  request   | in_valid / in_ready  | req_type .. port_c_pins
//  result    | out_valid / out_ready| read_data .. keyboard_scanned
//  config    | cfg_we (no wait)     | cfg_index, cfg_data
//
// One request a cycle while results are taken; an accepted beat sits in the input
// register, and the port state updates as it moves to the result register, where
// it raises out_valid. Reset is synchronous, clears all port state and both valid
// flags, and sets the config registers to their reset values. A stalled result
// holds; the input register still takes one more beat behind it.
module ppi8255_port_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [1:0] port_sel,
  input  logic [7:0] write_data,
  input  logic [7:0] key_row_data,
  input  logic [7:0] sound_read_data,
  input  logic       vsync,
  input  logic       tape_in,
  input  logic [7:0] port_c_pins,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic [7:0] port_a_out,
  output logic [7:0] port_c_out,
  output logic [3:0] keyboard_row,
  output logic [1:0] sound_bus_mode,
  output logic [7:0] sound_reg_sel,
  output logic       sound_write_strobe,
  output logic       keyboard_scanned
);

  ppi_pkg::in_beat_t  in_beat;
  ppi_pkg::in_beat_t  beat;
  ppi_pkg::out_beat_t result;
  ppi_pkg::out_beat_t out_beat;
  logic               beat_valid;
  logic               advance;

  always_comb begin
    in_beat.req_type        = ppi_pkg::req_t'(req_type);
    in_beat.port_sel        = ppi_pkg::port_t'(port_sel);
    in_beat.write_data      = write_data;
    in_beat.key_row_data    = key_row_data;
    in_beat.sound_read_data = sound_read_data;
    in_beat.vsync           = vsync;
    in_beat.tape_in         = tape_in;
    in_beat.port_c_pins     = port_c_pins;
  end

  ppi_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat       (beat),
    .advance    (advance)
  );

  ppi_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .advance   (advance),
    .result    (result)
  );

  ppi_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

  assign read_data          = out_beat.read_data;
  assign port_a_out         = out_beat.port_a_out;
  assign port_c_out         = out_beat.port_c_out;
  assign keyboard_row       = out_beat.keyboard_row;
  assign sound_bus_mode     = out_beat.sound_bus_mode;
  assign sound_reg_sel      = out_beat.sound_reg_sel;
  assign sound_write_strobe = out_beat.sound_write_strobe;
  assign keyboard_scanned   = out_beat.keyboard_scanned;

endmodule

// ===== sv/ppi_in_reg.sv =====
// Input register stage holding one accepted request beat.
module ppi_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppi_pkg::in_beat_t in_beat,
  output logic              beat_valid,
  output ppi_pkg::in_beat_t beat,
  input  logic              advance
);

  assign in_ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= in_beat;
    end
  end

endmodule

// ===== sv/ppi_core.sv =====
// Port latches, directions, sound/keyboard state and per-request result logic.
module ppi_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data,
  input  ppi_pkg::in_beat_t  beat,
  input  logic               advance,
  output ppi_pkg::out_beat_t result
);

  logic [2:0] maker_id;
  logic       refresh_fifty_hz;

  logic [7:0]         latch_a, latch_a_next;
  logic [7:0]         latch_c, latch_c_next;
  logic               dir_a_in, dir_a_in_next;
  logic [7:0]         dir_c_mask, dir_c_mask_next;
  logic [3:0]         row_reg, row_reg_next;
  ppi_pkg::bus_mode_t bus_mode_reg, bus_mode_reg_next;
  logic [7:0]         reg_select, reg_select_next;
  logic               scanned_flag, scanned_flag_next;

  logic [7:0] rd;
  logic       strobe;
  logic [7:0] drive_a_new;
  logic [7:0] drive_c_new;
  logic [7:0] bit_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      maker_id         <= ppi_pkg::MAKER_RESET;
      refresh_fifty_hz <= ppi_pkg::REFRESH_RESET;
    end else if (cfg_we) begin
      unique case (ppi_pkg::cfg_index_t'(cfg_index))
        ppi_pkg::CFG_MAKER_ID: maker_id         <= cfg_data;
        ppi_pkg::CFG_REFRESH:  refresh_fifty_hz <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    latch_a_next      = latch_a;
    latch_c_next      = latch_c;
    dir_a_in_next     = dir_a_in;
    dir_c_mask_next   = dir_c_mask;
    row_reg_next      = row_reg;
    bus_mode_reg_next = bus_mode_reg;
    reg_select_next   = reg_select;
    scanned_flag_next = scanned_flag;
    rd                = ppi_pkg::IDLE_BYTE;
    strobe            = 1'b0;
    bit_mask          = 8'd1 << beat.write_data[3:1];
    drive_a_new       = ppi_pkg::IDLE_BYTE;
    drive_c_new       = ppi_pkg::IDLE_BYTE;

    unique case (beat.req_type)
      ppi_pkg::REQ_READ: begin
        unique case (beat.port_sel)
          ppi_pkg::PORT_A: begin
            if (bus_mode_reg == ppi_pkg::BUS_READ) begin
              if (reg_select == ppi_pkg::KEYBOARD_REG) begin
                scanned_flag_next = 1'b1;
                rd = beat.key_row_data;
              end else begin
                rd = beat.sound_read_data;
              end
            end
          end
          ppi_pkg::PORT_B: begin
            rd = {beat.tape_in, 2'b00, refresh_fifty_hz, maker_id, beat.vsync};
          end
          ppi_pkg::PORT_C: begin
            rd = (beat.port_c_pins & dir_c_mask) | (latch_c & ~dir_c_mask);
          end
          ppi_pkg::PORT_CTRL: begin
            rd = ppi_pkg::IDLE_BYTE;
          end
        endcase
      end
      ppi_pkg::REQ_WRITE: begin
        unique case (beat.port_sel)
          ppi_pkg::PORT_A: begin
            latch_a_next = beat.write_data;
            drive_a_new  = dir_a_in ? ppi_pkg::IDLE_BYTE : beat.write_data;
            if (bus_mode_reg == ppi_pkg::BUS_WRITE) begin
              strobe = 1'b1;
            end else if (bus_mode_reg == ppi_pkg::BUS_SELECT) begin
              reg_select_next = drive_a_new;
            end
          end
          ppi_pkg::PORT_B: begin
          end
          ppi_pkg::PORT_C: begin
            // Row and bus mode follow the driven value, input bits read high
            latch_c_next      = beat.write_data;
            drive_c_new       = beat.write_data | dir_c_mask;
            row_reg_next      = drive_c_new[3:0];
            bus_mode_reg_next = ppi_pkg::bus_mode_t'(drive_c_new[7:6]);
            drive_a_new       = dir_a_in ? ppi_pkg::IDLE_BYTE : latch_a;
            if (bus_mode_reg_next == ppi_pkg::BUS_WRITE) begin
              strobe = 1'b1;
            end else if (bus_mode_reg_next == ppi_pkg::BUS_SELECT) begin
              reg_select_next = drive_a_new;
            end
          end
          ppi_pkg::PORT_CTRL: begin
            if (beat.write_data[ppi_pkg::CW_MODE_SET]) begin
              latch_a_next    = 8'h00;
              latch_c_next    = 8'h00;
              dir_a_in_next   = beat.write_data[ppi_pkg::CW_A_IN];
              dir_c_mask_next = {{4{beat.write_data[ppi_pkg::CW_CH_IN]}},
                                 {4{beat.write_data[ppi_pkg::CW_CL_IN]}}};
            end else if (beat.write_data[ppi_pkg::CW_BIT_VAL]) begin
              latch_c_next = latch_c | bit_mask;
            end else begin
              latch_c_next = latch_c & ~bit_mask;
            end
          end
        endcase
      end
      ppi_pkg::REQ_CLEAR_SCAN: begin
        scanned_flag_next = 1'b0;
      end
      ppi_pkg::REQ_NOP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_a      <= 8'h00;
      latch_c      <= 8'h00;
      dir_a_in     <= 1'b0;
      dir_c_mask   <= 8'h00;
      row_reg      <= 4'h0;
      bus_mode_reg <= ppi_pkg::BUS_INACTIVE;
      reg_select   <= 8'h00;
      scanned_flag <= 1'b0;
    end else if (advance) begin
      latch_a      <= latch_a_next;
      latch_c      <= latch_c_next;
      dir_a_in     <= dir_a_in_next;
      dir_c_mask   <= dir_c_mask_next;
      row_reg      <= row_reg_next;
      bus_mode_reg <= bus_mode_reg_next;
      reg_select   <= reg_select_next;
      scanned_flag <= scanned_flag_next;
    end
  end

  // Result shows the state after this request
  always_comb begin
    result.read_data          = rd;
    result.port_a_out         = dir_a_in_next ? ppi_pkg::IDLE_BYTE : latch_a_next;
    result.port_c_out         = latch_c_next | dir_c_mask_next;
    result.keyboard_row       = row_reg_next;
    result.sound_bus_mode     = bus_mode_reg_next;
    result.sound_reg_sel      = reg_select_next;
    result.sound_write_strobe = strobe;
    result.keyboard_scanned   = scanned_flag_next;
  end

endmodule

// ===== sv/ppi_out_reg.sv =====
// Result register stage holding one result beat until taken.
module ppi_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               beat_valid,
  input  ppi_pkg::out_beat_t result,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output ppi_pkg::out_beat_t out_beat
);

  logic slot_free;

  assign slot_free = !out_valid || out_ready;
  assign advance   = beat_valid && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= result;
    end
  end

endmodule

// ===== sv/ppi_checker.sv =====
// Port-level assertions for the port controller, bound to the top level.
module ppi_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic [7:0] port_a_out,
  input logic [1:0] sound_bus_mode,
  input logic       sound_write_strobe
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(port_a_out))
    else $error("result beat changed while stalled");

  a_strobe_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && sound_write_strobe |-> sound_bus_mode == ppi_pkg::BUS_WRITE)
    else $error("sound write strobe outside write bus mode");

  // A write never returns read data
  a_strobe_idle_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && sound_write_strobe |-> read_data == ppi_pkg::IDLE_BYTE)
    else $error("sound write beat carries read data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ppi8255_port_controller ppi_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .read_data          (read_data),
  .port_a_out         (port_a_out),
  .sound_bus_mode     (sound_bus_mode),
  .sound_write_strobe (sound_write_strobe)
);
